>>> rtl/slist_pkg.sv
// ----------------------------------------------------------------------------
// slist_pkg
// Shared widths, codes and controller types of the sorted insertion list.
// ----------------------------------------------------------------------------
`default_nettype none

package slist_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 2;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 6;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/slist_ctrl.sv
// ----------------------------------------------------------------------------
// slist_ctrl
// Sequencer: takes a command, runs the execute state, shows the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module slist_ctrl
  import slist_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  output logic         done,
  output dp_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // result beat is out; the next command may come in alongside it
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/slist_dp.sv
// ----------------------------------------------------------------------------
// slist_dp
// Row of compare-and-shift cells holding the sorted values, plus result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module slist_dp
  import slist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  input  wire logic        [MODE_W-1:0] mode,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic        [POS_W-1:0]  position,
  output logic signed      [DATA_W-1:0] read_value,
  output logic             [STAT_W-1:0] status,
  output logic             [ECNT_W-1:0] entry_count
);

  logic        [MODE_W-1:0] mode_q;
  logic signed [DATA_W-1:0] value_q;
  logic        [POS_W-1:0]  position_q;

  logic signed [DATA_W-1:0] entries  [CAPACITY];
  logic signed [DATA_W-1:0] ins_data [CAPACITY];
  logic signed [DATA_W-1:0] rem_data [CAPACITY];
  logic        [CAPACITY-1:0] at_mask;
  logic        [CNT_W-1:0]  count;
  logic        [CNT_W-1:0]  count_next;

  logic                     pos_ok;
  logic                     full;
  logic                     do_ins;
  logic                     do_rem;
  logic        [STAT_W-1:0] status_next;
  logic signed [DATA_W-1:0] rd_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q     <= mode;
      value_q    <= value;
      position_q <= position;
    end
  end

  // per-cell compare; mask is set from the insert point upward
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign at_mask[g] = (CNT_W'(g) >= count) || (entries[g] >= value_q);
      if (g == 0) begin : g_first
        assign ins_data[g] = at_mask[g] ? value_q : entries[g];
      end else begin : g_rest
        assign ins_data[g] = !at_mask[g]    ? entries[g]   :
                             !at_mask[g-1]  ? value_q      : entries[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign rem_data[g] = entries[g];
      end else begin : g_mid
        assign rem_data[g] = (IDX_W'(g) >= position_q[IDX_W-1:0]) ?
                             entries[g+1] : entries[g];
      end
    end
  endgenerate

  always_comb begin
    pos_ok      = CNT_W'(position_q) < count;
    full        = count >= CNT_W'(CAPACITY);
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    status_next = ST_OK;
    rd_next     = '0;
    count_next  = count;
    case (mode_q)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          rd_next = entries[position_q[IDX_W-1:0]];
        end
      end
      MODE_REMOVE: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          do_rem     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) begin
          entries[i] <= ins_data[i];
        end else if (do_rem) begin
          entries[i] <= rem_data[i];
        end
      end
      read_value  <= rd_next;
      status      <= status_next;
      entry_count <= ECNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sorted_list_insert_read_remove.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_read_remove
// Ascending list of signed values with insert, read by position and remove.
// ----------------------------------------------------------------------------
// result strobe (done): raised in the result state, which follows the execute state
// commands: one at a time, set by the single execute state
//   of the cell row; a new command is taken in the cycle the result shows
// reset: synchronous; empties the list, contents are left as they were
// results cannot be stalled, done is high for exactly one cycle per command
`default_nettype none

module sorted_list_insert_read_remove
  import slist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [MODE_W-1:0] mode,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic        [POS_W-1:0]  position,
  output logic                          done,
  output logic signed      [DATA_W-1:0] read_value,
  output logic             [STAT_W-1:0] status,
  output logic             [ECNT_W-1:0] entry_count
);

  dp_cmd_t cmd;

  slist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  slist_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .value       (value),
    .position    (position),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not enter execute");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("execute cycle not followed by result beat");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> entry_count == ECNT_W'(CAPACITY))
    else $error("full status with list not at capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> read_value == '0)
    else $error("nonzero read value on failed command");

endmodule

`default_nettype wire
